/* sv/assert_macros.svh */
// Assertion macros shared by the base64 decoder modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define B64D_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/b64d_pkg.sv */
// Types and constants for the base64 stream decoder.
// Used by the front, queue, back and top modules; depends on nothing.
package b64d_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Entries in the queue between classifier and decoder.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_SKIP = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2,
    STATUS_UNUSED   = 2'd3
  } status_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] sym;
    logic       last;
  } item_t;

endpackage

/* sv/base64_stream_decoder_top.sv */
// Channel  Handshake                 Payload
// input    in_valid_i / in_stall_o   ch_i[7:0], last_i
// output   out_valid_o / out_stall_i data_byte_o[7:0], byte_valid_o, status_o[1:0],
//                                    end_of_text_o
//
// One character a cycle is sustained while the output is not stalled; a character
// accepted is written into the queue and, once popped from its head, is decoded and,
// if it yields a result, loaded into the output register.
// Input stall is raised only while the two-entry queue is full.
// The back end stalls whenever its output register holds a word that is
// being stalled, whether or not the next character yields a result.
// Reset is asynchronous, active low, and clears the decode state and queue.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       end_of_text_o
);
  import b64d_pkg::*;

  item_t front_item;
  item_t back_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  b64d_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (front_item)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .item_i        (back_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .status_o      (status_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule

/* sv/b64d_front.sv */
// Front end: takes input words and classifies each character.
// Depends on b64d_pkg; feeds b64d_queue.
module b64d_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        ch_i,
  input  logic              last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64d_pkg::item_t   item_o
);
  import b64d_pkg::*;

  kind_e      kind;
  logic [5:0] sym;

  always_comb begin
    kind = KIND_DATA;
    sym  = 6'd0;
    if (ch_i >= 8'h41 && ch_i <= 8'h5A) begin
      sym = 6'(ch_i - 8'h41);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h7A) begin
      sym = 6'(ch_i - 8'h61 + 8'd26);
    end else if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      sym = 6'(ch_i - 8'h30 + 8'd52);
    end else if (ch_i == CH_PLUS) begin
      sym = 6'd62;
    end else if (ch_i == CH_SLASH) begin
      sym = 6'd63;
    end else if (ch_i == CH_PAD) begin
      kind = KIND_PAD;
    end else if (ch_i == CH_NEWLINE) begin
      kind = KIND_SKIP;
    end else begin
      kind = KIND_BAD;
    end
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign item_o.kind = kind;
  assign item_o.sym  = sym;
  assign item_o.last = last_i;

endmodule

/* sv/b64d_queue.sv */
// Short queue of classified characters between front and back.
// Depends on b64d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64d_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::item_t item_i,
  input  logic            pop_i,
  output b64d_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);
  import b64d_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `B64D_ASSERT(a_q_no_overflow, !(push_i && full_o), "queue written while full")
  `B64D_ASSERT(a_q_no_underflow, !(pop_i && empty_o), "queue read while empty")

endmodule

/* sv/b64d_back.sv */
// Back end: runs the decoder state on each classified character and
// holds the result word in an output register. Depends on b64d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  b64d_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic            byte_valid_o,
  output logic [1:0]      status_o,
  output logic            end_of_text_o
);
  import b64d_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [5:0] left_q, left_d;
  logic       pad_q, pad_d;
  logic       err_q, err_d;

  logic       have_byte;
  logic [7:0] byte_val;
  logic       has_result;
  status_e    status;
  logic       out_free;
  logic       load;

  logic       out_valid_q;
  logic [7:0] data_byte_q;
  logic       byte_valid_q;
  status_e    status_q;
  logic       eot_q;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !q_empty_i && out_free;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    pad_d     = pad_q;
    err_d     = err_q;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    case (item_i.kind)
      KIND_SKIP: begin
      end
      KIND_PAD: begin
        if (phase_q < 2'd2) begin
          err_d = 1'b1;
        end else begin
          pad_d   = 1'b1;
          left_d  = 6'd0;
          phase_d = phase_q + 2'd1;
        end
      end
      KIND_DATA: begin
        if (pad_q) begin
          err_d = 1'b1;
        end else begin
          phase_d = phase_q + 2'd1;
          case (phase_q)
            2'd0: begin
              left_d = item_i.sym;
            end
            2'd1: begin
              byte_val  = {left_q, item_i.sym[5:4]};
              left_d    = {2'b00, item_i.sym[3:0]};
              have_byte = 1'b1;
            end
            2'd2: begin
              byte_val  = {left_q[3:0], item_i.sym[5:2]};
              left_d    = {4'b0000, item_i.sym[1:0]};
              have_byte = 1'b1;
            end
            default: begin
              byte_val  = {left_q[1:0], item_i.sym};
              left_d    = 6'd0;
              have_byte = 1'b1;
            end
          endcase
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase

    // An invalid character outranks a short final group.
    if (err_d) begin
      status = STATUS_BAD_CHAR;
    end else if (item_i.last && phase_d != 2'd0) begin
      status = STATUS_BAD_LEN;
    end else begin
      status = STATUS_OK;
    end
    has_result = have_byte || item_i.last;

    // The final character of a text returns all decode state to its reset value.
    if (item_i.last) begin
      phase_d = 2'd0;
      left_d  = 6'd0;
      pad_d   = 1'b0;
      err_d   = 1'b0;
    end
  end

  assign load = pop_o && has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      left_q      <= 6'd0;
      pad_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        pad_q   <= pad_d;
        err_q   <= err_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_byte_q  <= byte_val;
      byte_valid_q <= have_byte;
      status_q     <= status;
      eot_q        <= item_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = data_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign status_o      = status_q;
  assign end_of_text_o = eot_q;

  `B64D_ASSERT_NEXT(a_back_last_clears, pop_o && item_i.last,
    phase_q == 2'd0 && !pad_q && !err_q, "state not cleared after final character")
  `B64D_ASSERT(a_back_pad_phase, !pad_q || phase_q == 2'd3 || phase_q == 2'd0,
    "padding seen at an impossible phase")

endmodule

/* sim/base64_stream_decoder_checker.sv */
// Watches both channels of the base64 stream decoder, predicts each decoded word
// and compares it with what the block delivers. Depends on b64d_pkg.
`timescale 1ns / 1ps

module base64_stream_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_valid_i,
  input  logic [1:0] status_i,
  input  logic       end_of_text_i,
  output int         mismatch_count_o,
  output int         words_due_o
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    status_e    status;
    logic       end_of_text;
  } decoded_word_t;

  decoded_word_t bytes_due [$];

  // Decode state of the text in progress.
  logic [1:0] sym_phase   = 2'd0;
  logic [5:0] carry_bits  = 6'd0;
  logic       pad_taken   = 1'b0;
  logic       bad_taken   = 1'b0;

  // Six-bit value of an alphabet character, or -1 for anything else.
  function automatic int sym_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic l);
    int            v;
    logic [5:0]    s;
    logic          have;
    logic [7:0]    b;
    decoded_word_t w;
    have = 1'b0;
    b    = 8'd0;
    if (c == CH_NEWLINE) begin
    end else if (c == CH_PAD) begin
      if (sym_phase < 2'd2) begin
        bad_taken = 1'b1;
      end else begin
        pad_taken  = 1'b1;
        carry_bits = 6'd0;
        sym_phase  = sym_phase + 2'd1;
      end
    end else begin
      v = sym_of(c);
      if (v < 0 || pad_taken) begin
        bad_taken = 1'b1;
      end else begin
        s = v[5:0];
        case (sym_phase)
          2'd0: begin
            carry_bits = s;
          end
          2'd1: begin
            b          = {carry_bits, s[5:4]};
            carry_bits = {2'b00, s[3:0]};
            have       = 1'b1;
          end
          2'd2: begin
            b          = {carry_bits[3:0], s[5:2]};
            carry_bits = {4'b0000, s[1:0]};
            have       = 1'b1;
          end
          default: begin
            b          = {carry_bits[1:0], s};
            carry_bits = 6'd0;
            have       = 1'b1;
          end
        endcase
        sym_phase = sym_phase + 2'd1;
      end
    end
    if (have || l) begin
      w.data_byte   = b;
      w.byte_valid  = have;
      w.end_of_text = l;
      if (bad_taken) w.status = STATUS_BAD_CHAR;
      else if (l && sym_phase != 2'd0) w.status = STATUS_BAD_LEN;
      else w.status = STATUS_OK;
      bytes_due.push_back(w);
    end
    if (l) begin
      sym_phase  = 2'd0;
      carry_bits = 6'd0;
      pad_taken  = 1'b0;
      bad_taken  = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin : watch
    decoded_word_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (bytes_due.size() == 0) begin
          $error("word with no expectation: data_byte %0h status %0d", data_byte_i, status_i);
          mismatch_count_o++;
        end else begin
          want = bytes_due.pop_front();
          if (data_byte_i !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte_i);
            mismatch_count_o++;
          end
          if (byte_valid_i !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid_i);
            mismatch_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatch_count_o++;
          end
          if (end_of_text_i !== want.end_of_text) begin
            $error("end_of_text: expected %0b, got %0b", want.end_of_text, end_of_text_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_char(ch_i, last_i);
      words_due_o = bytes_due.size();
    end
  end

endmodule

/* sim/base64_stream_decoder_top_tb.sv */
// Drives directed and random base64 texts into the stream decoder with random idling
// on both sides and gives the verdict. Depends on b64d_pkg, the decoder and its checker.
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int CHAR_TARGET = 1375;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] ch_i        = 8'd0;
  logic       last_i      = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic [1:0] status_o;
  logic       end_of_text_o;

  int         mismatch_count;
  int         words_due;
  int         cycle_count = 0;
  int         chars_sent  = 0;
  int         texts_sent  = 0;
  logic       calm        = 1'b0;
  logic       char_taken;
  logic [7:0] text_q [$];

  base64_stream_decoder_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .end_of_text_o(end_of_text_o)
  );

  base64_stream_decoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .ch_i            (ch_i),
    .last_i          (last_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_i     (data_byte_o),
    .byte_valid_i    (byte_valid_o),
    .status_i        (status_o),
    .end_of_text_i   (end_of_text_o),
    .mismatch_count_o(mismatch_count),
    .words_due_o     (words_due)
  );

  always #4 clk_i = ~clk_i;

  // Records at each edge whether the word on the input channel was taken, so that
  // the sender can read it at the following falling edge without a race.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= in_valid_i && !in_stall_o;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 8);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] char_of(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic send_word(input logic [7:0] c, input logic l);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= l;
    do @(negedge clk_i); while (!char_taken);
    chars_sent++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Sends the queued text with the last flag on its final character.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  task automatic maybe_newline();
    if ($urandom_range(0, 19) == 0) text_q.push_back(CH_NEWLINE);
  endtask

  task automatic make_text();
    int groups;
    int pads;
    int len;
    int r;
    if ($urandom_range(0, 99) < 75) begin
      // Well-formed text: whole groups, padding only in the final one.
      groups = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      pads   = $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) begin
          maybe_newline();
          if (g == groups - 1 && k >= 4 - pads) text_q.push_back(CH_PAD);
          else text_q.push_back(char_of($urandom_range(0, 63)));
        end
      end
      if ($urandom_range(0, 9) == 0) text_q.push_back(CH_NEWLINE);
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 5) text_q.push_back(char_of($urandom_range(0, 63)));
        else if (r == 5) text_q.push_back(CH_PAD);
        else if (r == 6) text_q.push_back(CH_NEWLINE);
        else text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A plain group, then the alphabet extremes.
    put_str("TWFu");
    send_text();
    put_str("A+z9");
    send_text();
    // Double padding with a newline in the middle.
    put_str("QQ");
    text_q.push_back(CH_NEWLINE);
    put_str("==");
    send_text();
    // Length that is not a multiple of four.
    put_str("Za/");
    send_text();
    // Invalid bytes and padding too early in the group.
    text_q.push_back(8'h00);
    text_q.push_back(CH_PAD);
    text_q.push_back(8'hFF);
    send_text();
    // A data symbol after padding.
    put_str("TQ=a");
    send_text();
    // A text that is nothing but a final newline.
    text_q.push_back(CH_NEWLINE);
    send_text();

    while (chars_sent < CHAR_TARGET) begin
      if (texts_sent == 40) calm = 1'b1;
      if (texts_sent == 90) calm = 1'b0;
      if (texts_sent == 100) begin
        // Hold the sender off until every word in flight has been delivered.
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (words_due != 0);
      end
      make_text();
      send_text();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_due != 0);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_top.sv
sim/base64_stream_decoder_checker.sv
sim/base64_stream_decoder_top_tb.sv
